[rtl/rlat_pkg.sv]
package rlat_pkg;

	// Default number of fraction bits of the cell vectors and results.
	localparam int FRAC_BITS_DEF = 16;

	// Lane count, one lane for each reciprocal component.
	localparam int NLANE = 9;

	// Magnitude of one cross term, an exact difference of two 62-bit products.
	localparam int CMW = 63;

	// Magnitude of the scaled cross term, cross term times the Q32 scale.
	localparam int MW = 98;

	// Magnitude of the cell volume, a sum of three 95-bit terms.
	localparam int VW = 96;

	// Quotient bits resolved by the divider, one per stage.
	localparam int DIV_STAGES = 32;

	// Taps of the shared volume line, from the abs stage to the last divider stage.
	localparam int VOL_LINE = DIV_STAGES + 2;

	// Cycles from an accepted request to its result register.
	localparam int LAT = 41;

	// Scale factors in Q32: two pi and one.
	localparam logic [34:0] TWO_PI_Q32 = 35'h6487ED511;
	localparam logic [34:0] ONE_Q32    = 35'h100000000;

	// Operand selection for the cross terms: lane j forms p*q - u*v over the
	// nine inputs a1_x .. a3_z.
	localparam int CT_P [NLANE] = '{4, 5, 3, 7, 8, 6, 1, 2, 0};
	localparam int CT_Q [NLANE] = '{8, 6, 7, 2, 0, 1, 5, 3, 4};
	localparam int CT_U [NLANE] = '{5, 3, 4, 8, 6, 7, 2, 0, 1};
	localparam int CT_V [NLANE] = '{7, 8, 6, 1, 2, 0, 4, 5, 3};

	// Volume information that the lanes need from the volume unit.
	typedef struct packed {
		logic vneg_s6;
		logic zero_s40;
	} vol_ctl_t;

endpackage

[rtl/rlat_lane.sv]
module rlat_lane #(
	parameter int FRAC_BITS = rlat_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      adv,
	input  logic                      mode,
	input  logic signed [31:0]        op_p,
	input  logic signed [31:0]        op_q,
	input  logic signed [31:0]        op_u,
	input  logic signed [31:0]        op_v,
	input  logic [rlat_pkg::VW-1:0]   vol_line [rlat_pkg::VOL_LINE],
	input  rlat_pkg::vol_ctl_t        ctl,
	output logic [rlat_pkg::CMW-1:0]  cm_s2,
	output logic                      cn_s2,
	output logic [31:0]               r_s41
);
	import rlat_pkg::*;

	localparam int TW = (MW + 2 * FRAC_BITS + 2 > VW + 66) ? MW + 2 * FRAC_BITS + 2 : VW + 66;

	logic signed [63:0] x_s1, y_s1;
	logic signed [64:0] diff;
	logic [31:0]        klo;
	logic [2:0]         khi;
	logic [63:0]        pll_s3;
	logic [62:0]        phl_s3;
	logic [34:0]        plh_s3;
	logic [33:0]        phh_s3;
	logic               cn_s3, cn_s4, cn_s5, cn_s6;
	logic               cz_s3, cz_s4, cz_s5, cz_s6;
	logic [MW-1:0]      m_s4, m_s5, m_s6;
	logic [TW-1:0]      t_s7;
	logic               neg_s7;
	logic [TW-1:0]      t_d   [DIV_STAGES+1];
	logic [31:0]        q_d   [DIV_STAGES+1];
	logic               sat_d [DIV_STAGES+1];
	logic               neg_d [DIV_STAGES+1];
	logic [32:0]        qv, qlim, qc;
	logic [31:0]        r_nxt;

	// The difference of the two products is exact; keep it as sign and magnitude.
	assign diff = 65'(x_s1) - 65'(y_s1);

	// Scale split into a low word and a three-bit high part.
	assign klo = mode ? TWO_PI_Q32[31:0] : ONE_Q32[31:0];
	assign khi = mode ? TWO_PI_Q32[34:32] : ONE_Q32[34:32];

	// Cross term, then the scale multiply as four partial products.
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= op_p * op_q;
			y_s1   <= op_u * op_v;
			cn_s2  <= diff[64];
			cm_s2  <= diff[64] ? CMW'(-diff) : CMW'(diff);
			pll_s3 <= 64'(cm_s2[31:0]) * 64'(klo);
			phl_s3 <= 63'(cm_s2[62:32]) * 63'(klo);
			plh_s3 <= 35'(cm_s2[31:0]) * 35'(khi);
			phh_s3 <= 34'(cm_s2[62:32]) * 34'(khi);
			cn_s3  <= cn_s2;
			cz_s3  <= (cm_s2 == '0);
			m_s4   <= MW'(pll_s3) + (MW'(phl_s3) << 32) + (MW'(plh_s3) << 32)
				+ (MW'(phh_s3) << 64);
			cn_s4  <= cn_s3;
			cz_s4  <= cz_s3;
			m_s5   <= m_s4;
			cn_s5  <= cn_s4;
			cz_s5  <= cz_s4;
			m_s6   <= m_s5;
			cn_s6  <= cn_s5;
			cz_s6  <= cz_s5;
		end
	end

	// Dividend 2N + D, sign of the result, and the overflow test against 2D * 2^32.
	always_ff @(posedge clk) begin
		if (adv) begin
			t_s7     <= (TW'(m_s6) << (2 * FRAC_BITS + 1)) + (TW'(vol_line[0]) << 32);
			neg_s7   <= !cz_s6 && (cn_s6 ^ ctl.vneg_s6);
			t_d[0]   <= t_s7;
			q_d[0]   <= '0;
			sat_d[0] <= (t_s7 >= (TW'(vol_line[1]) << 65));
			neg_d[0] <= neg_s7;
		end
	end

	// Restoring divider, one quotient bit per stage, most significant first.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [TW-1:0] dsr;
		logic          ge;

		assign dsr = TW'(vol_line[k + 2]) << (33 + DIV_STAGES - 1 - k);
		assign ge  = (t_d[k] >= dsr);

		always_ff @(posedge clk) begin
			if (adv) begin
				t_d[k+1]   <= ge ? t_d[k] - dsr : t_d[k];
				q_d[k+1]   <= {q_d[k][30:0], ge};
				sat_d[k+1] <= sat_d[k];
				neg_d[k+1] <= neg_d[k];
			end
		end
	end

	// Clamp to the signed range and apply the sign.
	always_comb begin
		qv    = sat_d[DIV_STAGES] ? 33'h100000000 : {1'b0, q_d[DIV_STAGES]};
		qlim  = neg_d[DIV_STAGES] ? 33'h080000000 : 33'h07FFFFFFF;
		qc    = (qv > qlim) ? qlim : qv;
		r_nxt = neg_d[DIV_STAGES] ? 32'(-qc[31:0]) : qc[31:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s41 <= ctl.zero_s40 ? '0 : r_nxt;
		end
	end

endmodule

[rtl/rlat_vol.sv]
module rlat_vol #(
	parameter int FRAC_BITS = rlat_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      adv,
	input  logic signed [31:0]        a1 [3],
	input  logic [rlat_pkg::CMW-1:0]  cm_s2 [3],
	input  logic                      cn_s2 [3],
	output logic [rlat_pkg::VW-1:0]   vol_line [rlat_pkg::VOL_LINE],
	output rlat_pkg::vol_ctl_t        ctl,
	output logic [47:0]               cell_volume_s41,
	output logic                      zero_s41
);
	import rlat_pkg::*;

	localparam int CV_TAPS = LAT - 6;

	logic [31:0]        am_s1 [3], am_s2 [3];
	logic               an_s1 [3], an_s2 [3];
	logic [63:0]        pl_s3 [3];
	logic [62:0]        ph_s3 [3];
	logic               sg_s3 [3], sg_s4 [3];
	logic [94:0]        term_s4 [3];
	logic signed [VW:0] sum_s5;
	logic signed [VW:0] sum_nxt;
	logic               vneg_s6;
	logic               zero_q [LAT - 5];
	logic [47:0]        cv_q [CV_TAPS];
	logic [VW:0]        rsum, rsh;
	logic [47:0]        cv_nxt;

	// Each a1 component times its cross term, in partial products.
	for (genvar i = 0; i < 3; i++) begin : g_term
		always_ff @(posedge clk) begin
			if (adv) begin
				am_s1[i]   <= a1[i][31] ? 32'(-a1[i]) : 32'(a1[i]);
				an_s1[i]   <= a1[i][31];
				am_s2[i]   <= am_s1[i];
				an_s2[i]   <= an_s1[i];
				pl_s3[i]   <= 64'(am_s2[i]) * 64'(cm_s2[i][31:0]);
				ph_s3[i]   <= 63'(am_s2[i]) * 63'(cm_s2[i][62:32]);
				sg_s3[i]   <= an_s2[i] ^ cn_s2[i];
				term_s4[i] <= 95'(pl_s3[i]) + (95'(ph_s3[i]) << 32);
				sg_s4[i]   <= sg_s3[i];
			end
		end
	end

	// Signed sum of the three terms.
	always_comb begin
		sum_nxt = '0;
		for (int i = 0; i < 3; i++) begin
			sum_nxt = sg_s4[i] ? sum_nxt - (VW + 1)'(term_s4[i])
				: sum_nxt + (VW + 1)'(term_s4[i]);
		end
	end

	// Rounded cell volume at FRAC_BITS fraction bits, saturated to 48 bits.
	always_comb begin
		rsum   = {1'b0, vol_line[0]} + ((VW + 1)'(1) << (2 * FRAC_BITS - 1));
		rsh    = rsum >> (2 * FRAC_BITS);
		cv_nxt = (|rsh[VW:48]) ? 48'hFFFFFFFFFFFF : rsh[47:0];
	end

	// Sum, magnitude and the shared delay lines.
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s5      <= sum_nxt;
			vneg_s6     <= sum_s5[VW];
			vol_line[0] <= sum_s5[VW] ? VW'(-sum_s5) : VW'(sum_s5);
			zero_q[0]   <= (sum_s5 == '0);
			cv_q[0]     <= cv_nxt;
			for (int j = 1; j < VOL_LINE; j++) begin
				vol_line[j] <= vol_line[j-1];
			end
			for (int j = 1; j < LAT - 5; j++) begin
				zero_q[j] <= zero_q[j-1];
			end
			for (int j = 1; j < CV_TAPS; j++) begin
				cv_q[j] <= cv_q[j-1];
			end
		end
	end

	assign ctl.vneg_s6     = vneg_s6;
	assign ctl.zero_s40    = zero_q[LAT - 7];
	assign zero_s41        = zero_q[LAT - 6];
	assign cell_volume_s41 = cv_q[CV_TAPS - 1];

endmodule

[rtl/reciprocal_lattice_3x3_top.sv]
// Reciprocal lattice of a 3x3 cell in fixed point.
// Input channel (in_valid / in_ready): one request carries the cell vectors
// a1, a2, a3 as signed Q16.16 components. Output channel (out_valid /
// out_ready): the reciprocal vectors r1, r2, r3 in Q16.16, saturated, the
// absolute cell volume in unsigned Q32.16 and a singular flag that is set,
// with all other outputs zero, when the volume is exactly zero.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes scale_mode,
// 1 for a two pi scale, 0 for a unit scale. cfg_ready is always high; write
// only while no request is in flight.
// One request is accepted every cycle while the pipeline is not stalled.
// The pipeline is the 32-stage restoring divider in each of the nine
// lanes plus the multiply and sum stages before it.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops in the same cycle; nothing is lost.
// Reset clears all valid bits and sets scale_mode to 1.
module reciprocal_lattice_3x3_top #(
	parameter int FRAC_BITS = rlat_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] a1_x,
	input  logic signed [31:0] a1_y,
	input  logic signed [31:0] a1_z,
	input  logic signed [31:0] a2_x,
	input  logic signed [31:0] a2_y,
	input  logic signed [31:0] a2_z,
	input  logic signed [31:0] a3_x,
	input  logic signed [31:0] a3_y,
	input  logic signed [31:0] a3_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] r1_x,
	output logic signed [31:0] r1_y,
	output logic signed [31:0] r1_z,
	output logic signed [31:0] r2_x,
	output logic signed [31:0] r2_y,
	output logic signed [31:0] r2_z,
	output logic signed [31:0] r3_x,
	output logic signed [31:0] r3_y,
	output logic signed [31:0] r3_z,
	output logic [47:0]        cell_volume,
	output logic               singular
);
	import rlat_pkg::*;

	logic               scale_mode_q;
	logic [LAT:1]       v_q;
	logic               adv;
	logic signed [31:0] a_in [NLANE];
	logic signed [31:0] a1_in [3];
	logic [CMW-1:0]     cm_s2 [NLANE];
	logic               cn_s2 [NLANE];
	logic [CMW-1:0]     vcm_s2 [3];
	logic               vcn_s2 [3];
	logic [VW-1:0]      vol_line [VOL_LINE];
	vol_ctl_t           ctl;
	logic [31:0]        r_s41 [NLANE];

	// Scale mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_mode_q <= 1'b1;
		end else if (cfg_valid) begin
			scale_mode_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// The pipeline moves whenever the result register is empty or being taken.
	assign adv       = !v_q[LAT] || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LAT-1:1], in_valid};
		end
	end

	assign a_in  = '{a1_x, a1_y, a1_z, a2_x, a2_y, a2_z, a3_x, a3_y, a3_z};
	assign a1_in = '{a1_x, a1_y, a1_z};

	// Nine lanes, one per reciprocal component.
	for (genvar j = 0; j < NLANE; j++) begin : g_lane
		rlat_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk      (clk),
			.adv      (adv),
			.mode     (scale_mode_q),
			.op_p     (a_in[CT_P[j]]),
			.op_q     (a_in[CT_Q[j]]),
			.op_u     (a_in[CT_U[j]]),
			.op_v     (a_in[CT_V[j]]),
			.vol_line (vol_line),
			.ctl      (ctl),
			.cm_s2    (cm_s2[j]),
			.cn_s2    (cn_s2[j]),
			.r_s41    (r_s41[j])
		);
	end

	// The first three cross terms form b1, which the volume unit merges with a1.
	for (genvar i = 0; i < 3; i++) begin : g_vsel
		assign vcm_s2[i] = cm_s2[i];
		assign vcn_s2[i] = cn_s2[i];
	end

	rlat_vol #(.FRAC_BITS(FRAC_BITS)) u_vol (
		.clk             (clk),
		.adv             (adv),
		.a1              (a1_in),
		.cm_s2           (vcm_s2),
		.cn_s2           (vcn_s2),
		.vol_line        (vol_line),
		.ctl             (ctl),
		.cell_volume_s41 (cell_volume),
		.zero_s41        (singular)
	);

	assign r1_x = r_s41[0];
	assign r1_y = r_s41[1];
	assign r1_z = r_s41[2];
	assign r2_x = r_s41[3];
	assign r2_y = r_s41[4];
	assign r2_z = r_s41[5];
	assign r3_x = r_s41[6];
	assign r3_y = r_s41[7];
	assign r3_z = r_s41[8];

endmodule

[rtl/rlat_chk.sv]
module rlat_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] r1_x,
	input logic signed [31:0] r1_y,
	input logic signed [31:0] r1_z,
	input logic signed [31:0] r2_x,
	input logic signed [31:0] r2_y,
	input logic signed [31:0] r2_z,
	input logic signed [31:0] r3_x,
	input logic signed [31:0] r3_y,
	input logic signed [31:0] r3_z,
	input logic [47:0]        cell_volume,
	input logic               singular
);

	// A waiting result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its value, checked on r1_x, r3_z and cell_volume.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(r1_x) && $stable(r3_z) && $stable(cell_volume))
		else $error("result changed while stalled");

	// The input side takes requests exactly when the result register can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready out of step with output");

	// A singular cell gives all-zero outputs.
	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> r1_x == 0 && r1_y == 0 && r1_z == 0 && r2_x == 0
			&& r2_y == 0 && r2_z == 0 && r3_x == 0 && r3_y == 0 && r3_z == 0
			&& cell_volume == 0)
		else $error("singular result with nonzero fields");

endmodule

bind reciprocal_lattice_3x3_top rlat_chk u_rlat_chk (.*);
